// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scanline unpacker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/pspu_pkg.sv -----
// ----------------------------------------------------------------------------
// Scanline unpacker package
// Types, register codes and the sample scaling function.
// ----------------------------------------------------------------------------
package pspu_pkg;

	localparam int BIT_DEPTH_W   = 5;
	localparam int COLOR_MODE_W  = 2;
	localparam int LINE_WIDTH_W  = 14;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 14;
	localparam int LINE_WIDTH_MAX = (1 << LINE_WIDTH_W) - 1;
	localparam int MAX_WIDTH_DEF = 8192;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd2;

	// Color modes.
	localparam logic [COLOR_MODE_W-1:0] MODE_GRAY  = 2'd0;
	localparam logic [COLOR_MODE_W-1:0] MODE_GA    = 2'd1;
	localparam logic [COLOR_MODE_W-1:0] MODE_RGB   = 2'd2;
	localparam logic [COLOR_MODE_W-1:0] MODE_RGBA  = 2'd3;

	localparam logic [BIT_DEPTH_W-1:0]  BIT_DEPTH_RST  = 5'd8;
	localparam logic [COLOR_MODE_W-1:0] COLOR_MODE_RST = MODE_RGBA;
	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 14'd1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef enum logic [2:0] {
		DEP_1,
		DEP_2,
		DEP_4,
		DEP_8,
		DEP_16
	} depth_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_in_line;
	} pixel_t;

	typedef struct packed {
		logic load;
		logic step;
	} samp_ctl_t;

	typedef struct packed {
		logic take;
		logic clear;
	} asm_ctl_t;

	function automatic depth_t decode_depth(input logic [BIT_DEPTH_W-1:0] bd);
		depth_t d;
		case (bd)
			5'd1:    d = DEP_1;
			5'd2:    d = DEP_2;
			5'd4:    d = DEP_4;
			5'd16:   d = DEP_16;
			default: d = DEP_8;
		endcase
		return d;
	endfunction

	// value*255/(2^d-1) equals the d-bit value repeated across the byte.
	function automatic logic [7:0] scale_sample(input logic [7:0] top, input depth_t d);
		logic [7:0] s;
		case (d)
			DEP_1:   s = {8{top[7]}};
			DEP_2:   s = {4{top[7:6]}};
			DEP_4:   s = {2{top[7:4]}};
			default: s = top;
		endcase
		return s;
	endfunction

endpackage

// ----- hdl/pspu_ifs.sv -----
// ----------------------------------------------------------------------------
// Scanline unpacker channels
// Byte input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface pspu_scan_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       line_end;

	modport source (output valid, data_byte, line_end, input ready);
	modport sink (input valid, data_byte, line_end, output ready);
endinterface

interface pspu_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       pixel_last_in_line;
	logic       run_last;

	modport source (output valid, red, green, blue, alpha, pixel_last_in_line, run_last,
		input ready);
	modport sink (input valid, red, green, blue, alpha, pixel_last_in_line, run_last,
		output ready);
endinterface

interface pspu_cfg_if;
	import pspu_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/pspu_sample_unit.sv -----
// ----------------------------------------------------------------------------
// Sample shift unit
// Holds the current byte and shifts one sample out per step, scaled to 8 bits.
// ----------------------------------------------------------------------------
module pspu_sample_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  pspu_pkg::samp_ctl_t ctl,
	input  pspu_pkg::depth_t   depth,
	input  logic [7:0]         data_byte,
	output logic [7:0]         sample,
	output logic               last
);
	import pspu_pkg::*;

	logic [7:0] shreg_q;
	logic [2:0] left_q;
	logic [2:0] shamt;
	logic [2:0] steps_m1;

	always_comb begin
		case (depth)
			DEP_1: begin
				shamt    = 3'd1;
				steps_m1 = 3'd7;
			end
			DEP_2: begin
				shamt    = 3'd2;
				steps_m1 = 3'd3;
			end
			DEP_4: begin
				shamt    = 3'd4;
				steps_m1 = 3'd1;
			end
			default: begin
				shamt    = 3'd0;
				steps_m1 = 3'd0;
			end
		endcase
	end

	assign sample = scale_sample(shreg_q, depth);
	assign last   = (left_q == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 3'd0;
		end else if (ctl.load) begin
			left_q <= steps_m1;
		end else if (ctl.step && !last) begin
			left_q <= left_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			shreg_q <= data_byte;
		end else if (ctl.step) begin
			shreg_q <= shreg_q << shamt;
		end
	end

endmodule

// ----- hdl/pspu_pixel_asm.sv -----
// ----------------------------------------------------------------------------
// Pixel assembler
// Gathers channel samples into a pixel and tracks the position in the line.
// ----------------------------------------------------------------------------
module pspu_pixel_asm #(
	parameter int CNT_W = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pspu_pkg::asm_ctl_t            ctl,
	input  logic [7:0]                    sample,
	input  logic [pspu_pkg::COLOR_MODE_W-1:0] color_mode,
	input  logic [CNT_W-1:0]              width,
	output logic                          done,
	output pspu_pkg::pixel_t              pix
);
	import pspu_pkg::*;

	logic [3:0][7:0] part_q;
	logic [3:0][7:0] merged;
	logic [1:0]      idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic            active;
	logic            complete;

	// Samples past the line width are padding and leave the state alone.
	assign active   = (cnt_q < width);
	assign complete = (idx_q >= color_mode);
	assign done     = active && complete;

	always_comb begin
		merged        = part_q;
		merged[idx_q] = sample;
	end

	always_comb begin
		pix.last_in_line = (({1'b0, cnt_q} + {{CNT_W{1'b0}}, 1'b1}) == {1'b0, width});
		case (color_mode)
			MODE_GRAY: begin
				pix.red   = merged[0];
				pix.green = merged[0];
				pix.blue  = merged[0];
				pix.alpha = ALPHA_OPAQUE;
			end
			MODE_GA: begin
				pix.red   = merged[0];
				pix.green = merged[0];
				pix.blue  = merged[0];
				pix.alpha = merged[1];
			end
			MODE_RGB: begin
				pix.red   = merged[0];
				pix.green = merged[1];
				pix.blue  = merged[2];
				pix.alpha = ALPHA_OPAQUE;
			end
			default: begin
				pix.red   = merged[0];
				pix.green = merged[1];
				pix.blue  = merged[2];
				pix.alpha = merged[3];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			idx_q  <= 2'd0;
			cnt_q  <= '0;
		end else if (ctl.clear) begin
			part_q <= '0;
			idx_q  <= 2'd0;
			cnt_q  <= '0;
		end else if (ctl.take && active) begin
			part_q <= merged;
			if (complete) begin
				idx_q <= 2'd0;
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ----- hdl/png_scanline_pixel_unpacker.sv -----
// ----------------------------------------------------------------------------
// PNG scanline pixel unpacker
// Unpacks bytes of an unfiltered scanline into RGBA8 pixels.
//
//   channel  dir  handshake      payload
//   scan     in   valid/ready    data_byte, line_end
//   pixel    out  valid/ready    red, green, blue, alpha, pixel_last_in_line,
//                                run_last
//   cfg      in   valid/ready    index, data (always ready)
//
// A byte is accepted in the idle state; the shift unit then steps out its
// samples (8/depth at depths 1, 2 and 4, one at depths 8 and 16) and the
// drain state hands over the last pixel. A depth-16 low byte is dropped in
// idle. A stalled pixel output holds the sample sequencer. Reset clears the
// settings, the state and the line position; no clearing pass is needed.
// ----------------------------------------------------------------------------
module png_scanline_pixel_unpacker #(
	parameter int MAX_WIDTH = pspu_pkg::MAX_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	pspu_scan_if.sink      scan,
	pspu_pixel_if.source   pixel,
	pspu_cfg_if.sink       cfg
);
	import pspu_pkg::*;

	localparam int EffMax = (MAX_WIDTH < LINE_WIDTH_MAX) ? MAX_WIDTH : LINE_WIDTH_MAX;
	localparam int CntW   = $clog2(EffMax + 1);
	localparam logic [LINE_WIDTH_W-1:0] EffMaxV = LINE_WIDTH_W'(EffMax);

	logic [BIT_DEPTH_W-1:0]  bit_depth_q;
	logic [COLOR_MODE_W-1:0] color_mode_q;
	logic [LINE_WIDTH_W-1:0] line_width_q;

	state_t state_q, state_d;
	depth_t depth;
	logic   skip_q;
	logic   end_q;
	logic   skip_case;
	logic   accept;
	logic   run_go;
	logic   out_free;
	logic   push_mid;
	logic   push_end;

	logic [LINE_WIDTH_W-1:0] lw_nz;
	logic [CntW-1:0]         width_eff;

	samp_ctl_t  sctl;
	asm_ctl_t   actl;
	logic [7:0] sample;
	logic       samp_last;
	logic       asm_done;
	pixel_t     asm_pix;

	pixel_t pend_q;
	logic   pend_v_q;
	pixel_t out_q;
	logic   out_last_q;
	logic   out_v_q;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q  <= BIT_DEPTH_RST;
			color_mode_q <= COLOR_MODE_RST;
			line_width_q <= LINE_WIDTH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BIT_DEPTH:  bit_depth_q  <= cfg.data[BIT_DEPTH_W-1:0];
				REG_COLOR_MODE: color_mode_q <= cfg.data[COLOR_MODE_W-1:0];
				REG_LINE_WIDTH: line_width_q <= cfg.data[LINE_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	assign depth     = decode_depth(bit_depth_q);
	assign lw_nz     = (line_width_q == '0) ? LINE_WIDTH_W'(1) : line_width_q;
	assign width_eff = (lw_nz > EffMaxV) ? CntW'(EffMaxV) : CntW'(lw_nz);

	assign skip_case = (depth == DEP_16) && skip_q;
	assign accept    = scan.valid && scan.ready;
	assign out_free  = !out_v_q || pixel.ready;
	// A new pixel can only displace the held one if the output slot is free.
	assign run_go    = (state_q == ST_RUN) && !(asm_done && pend_v_q && !out_free);
	assign push_mid  = run_go && asm_done && pend_v_q;
	assign push_end  = (state_q == ST_DRAIN) && pend_v_q && out_free;

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !skip_case) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (run_go && samp_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pend_v_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		scan.ready = (state_q == ST_IDLE);
		sctl.load  = accept;
		sctl.step  = run_go;
		actl.take  = run_go;
		actl.clear = (accept && skip_case && scan.line_end)
			|| (run_go && samp_last && end_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			skip_q  <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				end_q  <= scan.line_end;
				skip_q <= skip_case ? 1'b0 : (depth == DEP_16);
			end else if (run_go && samp_last && end_q) begin
				skip_q <= 1'b0;
			end
		end
	end

	pspu_sample_unit u_samp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sctl),
		.depth     (depth),
		.data_byte (scan.data_byte),
		.sample    (sample),
		.last      (samp_last)
	);

	pspu_pixel_asm #(
		.CNT_W (CntW)
	) u_asm (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (actl),
		.sample     (sample),
		.color_mode (color_mode_q),
		.width      (width_eff),
		.done       (asm_done),
		.pix        (asm_pix)
	);

	// The newest pixel waits in the hold register until the byte produces
	// another one or its run ends, which settles its run_last flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (run_go && asm_done) begin
				pend_v_q <= 1'b1;
			end else if (push_end) begin
				pend_v_q <= 1'b0;
			end
			if (push_mid || push_end) begin
				out_v_q <= 1'b1;
			end else if (pixel.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_go && asm_done) begin
			pend_q <= asm_pix;
		end
		if (push_mid || push_end) begin
			out_q      <= pend_q;
			out_last_q <= push_end;
		end
	end

	assign pixel.valid              = out_v_q;
	assign pixel.red                = out_q.red;
	assign pixel.green              = out_q.green;
	assign pixel.blue               = out_q.blue;
	assign pixel.alpha              = out_q.alpha;
	assign pixel.pixel_last_in_line = out_q.last_in_line;
	assign pixel.run_last           = out_last_q;

endmodule

// ----- hdl/pspu_checker.sv -----
// ----------------------------------------------------------------------------
// Scanline unpacker port checker
// Watches the top-level channels for ordering and output hold rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pspu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       scan_ready,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic [7:0] pix_red,
	input logic [7:0] pix_green,
	input logic [7:0] pix_blue,
	input logic [7:0] pix_alpha,
	input logic       pix_last_in_line,
	input logic       pix_run_last
);

	// A pixel that is not the last of its byte means the byte is still in work.
	`ASSERT_SAME(a_mid_run_busy, clk, arst_n, pix_valid && !pix_run_last, !scan_ready, "byte accepted while its pixels were still pending")

	// Nothing in a line follows its last pixel, so it also ends its byte's run.
	`ASSERT_SAME(a_line_last_ends_run, clk, arst_n, pix_valid && pix_last_in_line, pix_run_last, "last pixel of line not marked as last of its byte")

	`ASSERT_NEXT(a_pix_valid_hold, clk, arst_n, pix_valid && !pix_ready, pix_valid, "stalled pixel item withdrawn")

	`ASSERT_NEXT(a_pix_data_hold, clk, arst_n, pix_valid && !pix_ready, $stable({pix_red, pix_green, pix_blue, pix_alpha, pix_last_in_line, pix_run_last}), "stalled pixel item changed")

endmodule

bind png_scanline_pixel_unpacker pspu_checker u_pspu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.scan_ready       (scan.ready),
	.pix_valid        (pixel.valid),
	.pix_ready        (pixel.ready),
	.pix_red          (pixel.red),
	.pix_green        (pixel.green),
	.pix_blue         (pixel.blue),
	.pix_alpha        (pixel.alpha),
	.pix_last_in_line (pixel.pixel_last_in_line),
	.pix_run_last     (pixel.run_last)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scanline unpacker testbench
// Streams scanline bytes through the unpacker under several depth, color mode
// and width settings, predicts every RGBA8 pixel in a small scoreboard and
// compares each pixel field by field, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import pspu_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_in_line;
		logic       run_last;
	} rgba_px_t;

	class pixel_ledger;
		logic [BIT_DEPTH_W-1:0]  depth_reg;
		logic [COLOR_MODE_W-1:0] mode_reg;
		logic [LINE_WIDTH_W-1:0] width_reg;
		logic [31:0]             gathered;
		int                      chan_idx;
		bit                      skip_low;
		int                      px_count;
		rgba_px_t                pixels_due[$];
		int                      errors;

		function new();
			depth_reg = BIT_DEPTH_RST;
			mode_reg  = COLOR_MODE_RST;
			width_reg = LINE_WIDTH_RST;
			clear_line();
			errors = 0;
		endfunction

		function void clear_line();
			gathered = '0;
			chan_idx = 0;
			skip_low = 1'b0;
			px_count = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_BIT_DEPTH:  depth_reg = data[BIT_DEPTH_W-1:0];
				REG_COLOR_MODE: mode_reg = data[COLOR_MODE_W-1:0];
				REG_LINE_WIDTH: width_reg = data[LINE_WIDTH_W-1:0];
				default: ;
			endcase
		endfunction

		function int depth_bits();
			if (depth_reg == 5'd1 || depth_reg == 5'd2 || depth_reg == 5'd4 ||
					depth_reg == 5'd16)
				return int'(depth_reg);
			return 8;
		endfunction

		function int width_px();
			int w;
			w = int'(width_reg);
			if (w == 0)
				w = 1;
			if (w > MAX_WIDTH_DEF)
				w = MAX_WIDTH_DEF;
			return w;
		endfunction

		// Stores one 8-bit sample; returns 1 when it finishes a pixel.
		function bit place_sample(logic [7:0] sample, output rgba_px_t px);
			int nch;
			int idx;
			int w;
			px = '0;
			nch = int'(mode_reg) + 1;
			idx = chan_idx;
			w = width_px();
			if (px_count >= w)
				return 1'b0;
			gathered[8*idx +: 8] = sample;
			if (idx + 1 < nch) begin
				chan_idx = idx + 1;
				return 1'b0;
			end
			chan_idx = 0;
			case (mode_reg)
				MODE_GRAY: begin
					px.red = gathered[7:0];
					px.green = gathered[7:0];
					px.blue = gathered[7:0];
					px.alpha = ALPHA_OPAQUE;
				end
				MODE_GA: begin
					px.red = gathered[7:0];
					px.green = gathered[7:0];
					px.blue = gathered[7:0];
					px.alpha = gathered[15:8];
				end
				MODE_RGB: begin
					px.red = gathered[7:0];
					px.green = gathered[15:8];
					px.blue = gathered[23:16];
					px.alpha = ALPHA_OPAQUE;
				end
				default: begin
					px.red = gathered[7:0];
					px.green = gathered[15:8];
					px.blue = gathered[23:16];
					px.alpha = gathered[31:24];
				end
			endcase
			px.last_in_line = (px_count + 1 == w);
			px.run_last = 1'b0;
			px_count = px_count + 1;
			return 1'b1;
		endfunction

		function void note_byte(logic [7:0] data_byte, logic line_end);
			rgba_px_t made[$];
			rgba_px_t px;
			int d;
			int maxv;
			int v;
			d = depth_bits();
			if (d == 16) begin
				if (skip_low) begin
					skip_low = 1'b0;
				end else begin
					skip_low = 1'b1;
					if (place_sample(data_byte, px))
						made.push_back(px);
				end
			end else if (d == 8) begin
				skip_low = 1'b0;
				if (place_sample(data_byte, px))
					made.push_back(px);
			end else begin
				skip_low = 1'b0;
				maxv = (1 << d) - 1;
				for (int pos = 0; pos < 8; pos += d) begin
					v = (int'(data_byte) >> (8 - d - pos)) & maxv;
					if (place_sample(8'(v * 255 / maxv), px))
						made.push_back(px);
				end
			end
			if (made.size() > 0)
				made[made.size()-1].run_last = 1'b1;
			foreach (made[i])
				pixels_due.push_back(made[i]);
			if (line_end)
				clear_line();
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_pixel(rgba_px_t got);
			rgba_px_t want;
			if (pixels_due.size() == 0) begin
				$display("%0t: unexpected pixel, expected none, actual %p", $time, got);
				errors++;
				return;
			end
			want = pixels_due.pop_front();
			compare_field("red", want.red, got.red);
			compare_field("green", want.green, got.green);
			compare_field("blue", want.blue, got.blue);
			compare_field("alpha", want.alpha, got.alpha);
			compare_field("pixel_last_in_line", want.last_in_line, got.last_in_line);
			compare_field("run_last", want.run_last, got.run_last);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pspu_scan_if  scan_ch ();
	pspu_pixel_if pix_ch ();
	pspu_cfg_if   cfg_ch ();

	png_scanline_pixel_unpacker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_ch),
		.pixel  (pix_ch),
		.cfg    (cfg_ch)
	);

	pixel_ledger ledger = new();

	// Idle odds in percent for the byte sender and the pixel receiver.
	int send_pct  = 0;
	int stall_pct = 0;

	// What the testbench last wrote, used to size well-formed lines.
	int cur_depth = 8;
	int cur_mode  = 3;
	int cur_width = 1;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && scan_ch.valid && scan_ch.ready)
			ledger.note_byte(scan_ch.data_byte, scan_ch.line_end);
	end

	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready)
			ledger.write_reg(cfg_ch.index, cfg_ch.data);
	end

	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready)
			ledger.check_pixel(rgba_px_t'({pix_ch.red, pix_ch.green, pix_ch.blue,
				pix_ch.alpha, pix_ch.pixel_last_in_line, pix_ch.run_last}));
	end

	initial begin
		pix_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				pix_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			pix_ch.ready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] data_byte, input logic line_end);
		if ($urandom_range(0, 99) < send_pct) begin
			scan_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		scan_ch.valid <= 1'b1;
		scan_ch.data_byte <= data_byte;
		scan_ch.line_end <= line_end;
		do
			@(posedge clk);
		while (!scan_ch.ready);
	endtask

	// The write strobe drops for one cycle after each write.
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_BIT_DEPTH:  cur_depth = int'(data[BIT_DEPTH_W-1:0]);
			REG_COLOR_MODE: cur_mode = int'(data[COLOR_MODE_W-1:0]);
			REG_LINE_WIDTH: cur_width = int'(data[LINE_WIDTH_W-1:0]);
			default: ;
		endcase
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Holds the sender until every predicted pixel is out and the block has
	// had time to finish a byte that yields nothing.
	task automatic settle();
		scan_ch.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pixels_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic random_config(input bit idle_allowed);
		int r;
		int dbits;
		int maxw;
		logic [4:0] depth;
		r = $urandom_range(0, 11);
		case (r)
			0, 5:    depth = 5'd1;
			1, 6:    depth = 5'd2;
			2, 7:    depth = 5'd4;
			3, 8:    depth = 5'd8;
			4, 9:    depth = 5'd16;
			default: depth = 5'($urandom_range(0, 31));
		endcase
		write_cfg(REG_BIT_DEPTH, {9'($urandom), depth});
		write_cfg(REG_COLOR_MODE, {12'($urandom), 2'($urandom_range(0, 3))});
		dbits = (cur_depth == 1 || cur_depth == 2 || cur_depth == 4 || cur_depth == 16) ?
			cur_depth : 8;
		maxw = 192 / ((cur_mode + 1) * dbits);
		if (maxw < 1)
			maxw = 1;
		r = $urandom_range(0, 19);
		case (r)
			0:       write_cfg(REG_LINE_WIDTH, 14'd0);
			1:       write_cfg(REG_LINE_WIDTH, 14'(LINE_WIDTH_MAX));
			2:       write_cfg(REG_LINE_WIDTH, 14'($urandom_range(MAX_WIDTH_DEF, LINE_WIDTH_MAX)));
			default: write_cfg(REG_LINE_WIDTH, 14'($urandom_range(1, maxw)));
		endcase
		case ($urandom_range(0, 3))
			0: send_pct = 0;
			1: send_pct = 10;
			2: send_pct = 30;
			default: send_pct = 60;
		endcase
		case ($urandom_range(0, 3))
			0: stall_pct = 0;
			1: stall_pct = 10;
			2: stall_pct = 30;
			default: stall_pct = 60;
		endcase
		if (!idle_allowed) begin
			send_pct = 0;
			stall_pct = 0;
		end
	endtask

	// Sends one scanline: mostly exact length, sometimes cut short, padded
	// past the width, or left open without a line end.
	task automatic send_line(output int sent);
		int dbits;
		int w;
		int full;
		int kind;
		int n;
		logic [7:0] b;
		dbits = (cur_depth == 1 || cur_depth == 2 || cur_depth == 4) ? cur_depth :
			(cur_depth == 16 ? 16 : 8);
		w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : cur_width);
		full = (w * (cur_mode + 1) * dbits + 7) / 8;
		if (full > 24)
			full = 24;
		kind = $urandom_range(0, 9);
		if (kind <= 5)
			n = full;
		else if (kind <= 7 || kind == 9)
			n = $urandom_range(1, full);
		else
			n = full + $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0:       b = 8'h00;
				1:       b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			send_byte(b, (kind != 9) && (i == n - 1));
		end
		sent = n;
	endtask

	initial begin
		int rnd_items;
		int sent;
		arst_n <= 1'b0;
		scan_ch.valid <= 1'b0;
		scan_ch.data_byte <= 8'h00;
		scan_ch.line_end <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_BIT_DEPTH;
		cfg_ch.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one RGBA pixel per line, the rest is padding.
		stall_pct = 30;
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h12, 1'b1);
		settle();

		write_cfg(REG_BIT_DEPTH, 14'd1);
		write_cfg(REG_COLOR_MODE, 14'(MODE_GRAY));
		write_cfg(REG_LINE_WIDTH, 14'd6);
		send_byte(8'hA5, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();

		// A zero width acts as a single pixel.
		write_cfg(REG_BIT_DEPTH, 14'd2);
		write_cfg(REG_COLOR_MODE, 14'(MODE_GA));
		write_cfg(REG_LINE_WIDTH, 14'd0);
		send_byte(8'h1B, 1'b1);
		settle();

		// The line ends with a pixel half gathered, which is dropped.
		write_cfg(REG_BIT_DEPTH, 14'd4);
		write_cfg(REG_COLOR_MODE, 14'(MODE_RGB));
		write_cfg(REG_LINE_WIDTH, 14'(LINE_WIDTH_MAX));
		send_byte(8'hF0, 1'b0);
		send_byte(8'h0F, 1'b1);
		settle();

		// Illegal depth acts as 8; the mode drops to gray+alpha with three
		// channels already gathered, so the next sample closes the pixel.
		write_cfg(REG_BIT_DEPTH, 14'd3);
		write_cfg(REG_COLOR_MODE, 14'(MODE_RGBA));
		write_cfg(REG_LINE_WIDTH, 14'd2);
		send_byte(8'h10, 1'b0);
		send_byte(8'h20, 1'b0);
		send_byte(8'h30, 1'b0);
		settle();
		write_cfg(REG_COLOR_MODE, 14'(MODE_GA));
		send_byte(8'h40, 1'b0);
		send_byte(8'h50, 1'b1);
		settle();

		// Depth 16 keeps high bytes; switching depth right after a high byte
		// makes the following byte a sample again.
		write_cfg(REG_BIT_DEPTH, 14'd16);
		write_cfg(REG_COLOR_MODE, 14'(MODE_GRAY));
		write_cfg(REG_LINE_WIDTH, 14'd3);
		send_byte(8'hAB, 1'b0);
		send_byte(8'hCD, 1'b0);
		send_byte(8'hEF, 1'b0);
		settle();
		write_cfg(REG_BIT_DEPTH, 14'h3FFF);
		send_byte(8'h01, 1'b1);
		settle();

		// The last stretch of random lines runs without idling.
		rnd_items = 0;
		while (rnd_items < 390) begin
			random_config(rnd_items < 300);
			repeat ($urandom_range(1, 4)) begin
				send_line(sent);
				rnd_items += sent;
				if ($urandom_range(0, 7) == 0)
					settle();
			end
			settle();
		end

		if (ledger.errors == 0 && ledger.pixels_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
